// ----- sv/bba_pkg.sv -----
// Package for the buddy block allocator: field widths, request codes,
// walker state type, the structs between top level and walker, and log2 helper.
// No dependencies.
`default_nettype none

package bba_pkg;

    // Default tree shape
    localparam int LEVELS_DEF      = 4;
    localparam int BLOCK_SHIFT_DEF = 16;

    // Field widths
    localparam int REQ_W = 21;  // request_bytes
    localparam int OFF_W = 20;  // release_offset / block_offset
    localparam int LOG_W = 5;   // log2 values of a request

    // Request kinds carried in tuser
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Walker sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,    // clearing pass over the node memory after reset
        ST_IDLE,
        ST_A_RD,     // allocate search: read node
        ST_A_CHK,    // allocate search: test node
        ST_A_UP,     // allocate search: backtrack
        ST_S_CHK,    // split the found leaf or mark it
        ST_S_RIGHT,  // clear right child of a split node
        ST_R_RD,     // release search: read node
        ST_R_CHK,    // release search: test node
        ST_R_UP,     // release search: return to parent or sibling
        ST_M_RDL,    // merge: read left child
        ST_M_RDR,    // merge: read right child
        ST_M_CHK,    // merge: test both children
        ST_OUT       // result waits for the output register
    } walk_state_t;

    // Per-node marks
    typedef struct packed {
        logic split;
        logic used;
    } node_t;

    // Decoded request handed to the walker
    typedef struct packed {
        logic             mode;
        logic [OFF_W-1:0] rel_off;
        logic [LOG_W-1:0] fit_lvl;    // lowest level that holds the request
        logic [LOG_W-1:0] split_lvl;  // lowest level still split further
        logic             req_zero;
    } walk_req_t;

    // Walker status back to the top level
    typedef struct packed {
        logic             idle;
        logic             res_valid;
        logic             res_ok;
        logic [OFF_W-1:0] res_off;
    } walk_stat_t;

    // Index of the highest set bit (0 for zero)
    function automatic logic [LOG_W-1:0] floor_log2(input logic [REQ_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i < REQ_W; i++) begin
            if (v[i]) begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bba_walk.sv -----
// Tree walker for the buddy allocator: node mark memory, clearing pass and the
// search / split / release / merge sequencer. Depends on bba_pkg.
`default_nettype none

module bba_walk #(
    parameter int LEVELS      = bba_pkg::LEVELS_DEF,
    parameter int BLOCK_SHIFT = bba_pkg::BLOCK_SHIFT_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      start,
    input  wire bba_pkg::walk_req_t  req,
    input  wire                      res_take,
    output bba_pkg::walk_stat_t      stat
);

    localparam int NW         = LEVELS + 1;
    localparam int NODE_COUNT = (2 ** NW) - 1;
    localparam int LW         = $clog2(LEVELS + 1);
    localparam int CMP_W      = (LW > bba_pkg::LOG_W) ? LW : bba_pkg::LOG_W;
    localparam int SW         = LEVELS + BLOCK_SHIFT;
    localparam int AW         = (SW > bba_pkg::OFF_W) ? SW : bba_pkg::OFF_W;

    localparam logic [NW-1:0]     NODE_LAST = NW'(NODE_COUNT - 1);
    localparam logic [LW-1:0]     LVL_TOP   = LW'(LEVELS);
    localparam logic [LEVELS-1:0] POS_ONE   = LEVELS'(1);

    bba_pkg::walk_state_t state_reg, state_next;
    logic [NW-1:0]        k_reg, k_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic [LEVELS-1:0]    pos_reg, pos_next;
    logic                 hit_reg, hit_next;
    bba_pkg::walk_req_t   req_reg, req_next;
    bba_pkg::node_t       lsave_reg, lsave_next;
    logic                 res_ok_reg, res_ok_next;
    logic [bba_pkg::OFF_W-1:0] res_off_reg, res_off_next;

    // Node mark memory: one write and one registered read per cycle
    bba_pkg::node_t node_mem [NODE_COUNT];
    bba_pkg::node_t mem_rdata_reg;
    logic           mem_we;
    logic [NW-1:0]  mem_waddr;
    bba_pkg::node_t mem_wdata;
    logic [NW-1:0]  mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= node_mem[mem_raddr];
    end

    // Tree arithmetic on the current node
    logic [NW-1:0]     left_idx, right_idx, parent_idx;
    logic [LEVELS-1:0] rpos, pos_cur_bit;
    logic [AW-1:0]     addr_ext, start_ext, rstart_ext;
    logic [CMP_W-1:0]  lvl_cmp, fit_cmp, split_cmp;
    logic              is_leaf, node_free;

    assign left_idx    = {k_reg[NW-2:0], 1'b1};
    assign right_idx   = left_idx + NW'(1);
    assign parent_idx  = (k_reg - NW'(1)) >> 1;
    assign pos_cur_bit = POS_ONE << lvl_reg;
    assign rpos        = pos_reg | (POS_ONE << (lvl_reg - LW'(1)));
    assign addr_ext    = AW'(req_reg.rel_off);
    assign start_ext   = AW'(pos_reg) << BLOCK_SHIFT;
    assign rstart_ext  = AW'(rpos) << BLOCK_SHIFT;
    assign lvl_cmp     = CMP_W'(lvl_reg);
    assign fit_cmp     = CMP_W'(req_reg.fit_lvl);
    assign split_cmp   = CMP_W'(req_reg.split_lvl);
    assign is_leaf     = !mem_rdata_reg.split || (lvl_reg == '0);
    assign node_free   = !mem_rdata_reg.split && !mem_rdata_reg.used;

    // State and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bba_pkg::ST_CLEAR;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
        lvl_reg     <= lvl_next;
        pos_reg     <= pos_next;
        hit_reg     <= hit_next;
        req_reg     <= req_next;
        lsave_reg   <= lsave_next;
        res_ok_reg  <= res_ok_next;
        res_off_reg <= res_off_next;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        lvl_next     = lvl_reg;
        pos_next     = pos_reg;
        hit_next     = hit_reg;
        req_next     = req_reg;
        lsave_next   = lsave_reg;
        res_ok_next  = res_ok_reg;
        res_off_next = res_off_reg;
        mem_we       = 1'b0;
        mem_waddr    = k_reg;
        mem_wdata    = '0;
        mem_raddr    = k_reg;

        case (state_reg)
            bba_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                if (k_reg == NODE_LAST) begin
                    k_next     = '0;
                    state_next = bba_pkg::ST_IDLE;
                end else begin
                    k_next = k_reg + NW'(1);
                end
            end

            bba_pkg::ST_IDLE: begin
                if (start) begin
                    req_next     = req;
                    k_next       = '0;
                    lvl_next     = LVL_TOP;
                    pos_next     = '0;
                    hit_next     = 1'b0;
                    res_ok_next  = 1'b0;
                    res_off_next = '0;
                    state_next   = (req.mode == bba_pkg::MODE_ALLOC) ?
                                   bba_pkg::ST_A_RD : bba_pkg::ST_R_RD;
                end
            end

            // Allocate: depth-first search for the leftmost free fitting leaf
            bba_pkg::ST_A_RD: begin
                state_next = bba_pkg::ST_A_CHK;
            end

            bba_pkg::ST_A_CHK: begin
                if (lvl_cmp < fit_cmp || mem_rdata_reg.used) begin
                    state_next = bba_pkg::ST_A_UP;
                end else if (is_leaf) begin
                    state_next = bba_pkg::ST_S_CHK;
                end else begin
                    k_next     = left_idx;
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = bba_pkg::ST_A_RD;
                end
            end

            bba_pkg::ST_A_UP: begin
                if (k_reg == '0) begin
                    res_ok_next = 1'b0;
                    state_next  = bba_pkg::ST_OUT;
                end else if (k_reg[0]) begin
                    // left child: try its right sibling
                    k_next     = k_reg + NW'(1);
                    pos_next   = pos_reg | pos_cur_bit;
                    state_next = bba_pkg::ST_A_RD;
                end else begin
                    k_next   = parent_idx;
                    lvl_next = lvl_reg + LW'(1);
                    pos_next = pos_reg & ~pos_cur_bit;
                end
            end

            // Halve the found leaf down the left side, then mark it
            bba_pkg::ST_S_CHK: begin
                mem_we = 1'b1;
                if (lvl_reg != '0 && lvl_cmp >= split_cmp) begin
                    mem_wdata.split = 1'b1;
                    state_next      = bba_pkg::ST_S_RIGHT;
                end else begin
                    mem_wdata.used = !req_reg.req_zero;
                    res_ok_next    = 1'b1;
                    res_off_next   = start_ext[bba_pkg::OFF_W-1:0];
                    state_next     = bba_pkg::ST_OUT;
                end
            end

            bba_pkg::ST_S_RIGHT: begin
                // left child is rewritten when it is split or marked
                mem_we     = 1'b1;
                mem_waddr  = right_idx;
                k_next     = left_idx;
                lvl_next   = lvl_reg - LW'(1);
                state_next = bba_pkg::ST_S_CHK;
            end

            // Release: search for the leaf that starts at the offset
            bba_pkg::ST_R_RD: begin
                state_next = bba_pkg::ST_R_CHK;
            end

            bba_pkg::ST_R_CHK: begin
                if (is_leaf) begin
                    if (addr_ext == start_ext) begin
                        mem_we   = 1'b1;
                        hit_next = 1'b1;
                    end
                    state_next = bba_pkg::ST_R_UP;
                end else if (addr_ext == rstart_ext) begin
                    k_next     = right_idx;
                    lvl_next   = lvl_reg - LW'(1);
                    pos_next   = rpos;
                    state_next = bba_pkg::ST_R_RD;
                end else begin
                    k_next     = left_idx;
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = bba_pkg::ST_R_RD;
                end
            end

            bba_pkg::ST_R_UP: begin
                if (k_reg == '0) begin
                    res_ok_next = hit_reg;
                    state_next  = bba_pkg::ST_OUT;
                end else if (k_reg[0] && !hit_reg) begin
                    // left subtree missed: search the right one
                    k_next     = k_reg + NW'(1);
                    pos_next   = pos_reg | pos_cur_bit;
                    state_next = bba_pkg::ST_R_RD;
                end else begin
                    k_next     = parent_idx;
                    lvl_next   = lvl_reg + LW'(1);
                    pos_next   = pos_reg & ~pos_cur_bit;
                    state_next = bba_pkg::ST_M_RDL;
                end
            end

            // Merge two free unsplit buddies into their parent
            bba_pkg::ST_M_RDL: begin
                mem_raddr  = left_idx;
                state_next = bba_pkg::ST_M_RDR;
            end

            bba_pkg::ST_M_RDR: begin
                mem_raddr  = right_idx;
                lsave_next = mem_rdata_reg;
                state_next = bba_pkg::ST_M_CHK;
            end

            bba_pkg::ST_M_CHK: begin
                if (!lsave_reg.split && !lsave_reg.used && node_free) begin
                    mem_we = 1'b1;
                end
                state_next = bba_pkg::ST_R_UP;
            end

            bba_pkg::ST_OUT: begin
                if (res_take) begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    assign stat.idle      = (state_reg == bba_pkg::ST_IDLE);
    assign stat.res_valid = (state_reg == bba_pkg::ST_OUT);
    assign stat.res_ok    = res_ok_reg;
    assign stat.res_off   = res_off_reg;

    // Checks
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == bba_pkg::ST_IDLE)
        else $error("request started while walker busy");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bba_pkg::ST_IDLE || state_reg == bba_pkg::ST_OUT) |-> !mem_we)
        else $error("node memory written outside a walk");

    a_lvl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != bba_pkg::ST_CLEAR && state_reg != bba_pkg::ST_IDLE
            |-> lvl_reg <= LVL_TOP)
        else $error("level above root");

    a_release_zero_off: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bba_pkg::ST_OUT && req_reg.mode == bba_pkg::MODE_RELEASE
            |-> res_off_reg == '0)
        else $error("release returned a nonzero offset");

    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bba_pkg::ST_CLEAR && state_next == bba_pkg::ST_IDLE
            |-> k_reg == NODE_LAST)
        else $error("clearing pass ended early");

endmodule

`default_nettype wire

// ----- sv/buddy_block_allocator_top.sv -----
// Buddy block allocator top level: stream ports, request decode and result
// register around the tree walker. Depends on bba_pkg and bba_walk.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | [20:0] request_bytes, [40:21] rel. offs | [0] mode (0 alloc, 1 release)
//  m_      | out | [19:0] block_offset                     | [0] ok
//
// After reset a clearing pass writes all 2^(LEVELS+1)-1 nodes (31 by default)
// before s_tready rises. One item at a time: the walker reads nodes through the
// registered read port of the node memory. After the request is accepted,
// allocation tests nodes, backtracks, splits the found leaf and marks it;
// release tests nodes, steps over to siblings and ascends with merge; then the
// result waits in the result state.
// s_tready returns once the result is in the output register, which holds it
// while m_tready is low.
`default_nettype none

module buddy_block_allocator_top #(
    parameter int LEVELS      = bba_pkg::LEVELS_DEF,
    parameter int BLOCK_SHIFT = bba_pkg::BLOCK_SHIFT_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [47:0] s_tdata,   // [20:0] request_bytes, [40:21] release_offset
    input  wire [0:0]  s_tuser,   // [0] mode
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [23:0] m_tdata,  // [19:0] block_offset
    output logic [0:0]  m_tuser   // [0] ok
);

    localparam logic [6:0] BS_W7 = 7'(BLOCK_SHIFT);

    bba_pkg::walk_req_t  req;
    bba_pkg::walk_stat_t stat;
    logic                start;
    logic                res_take;

    // Request decode: log2 bounds of the byte count
    logic [bba_pkg::REQ_W-1:0] n, n_dec;
    logic [bba_pkg::LOG_W-1:0] need, flog;
    logic [6:0]                need7, sp7, fit7, split7;

    assign n      = s_tdata[bba_pkg::REQ_W-1:0];
    assign n_dec  = n - bba_pkg::REQ_W'(1);
    assign need   = (n > bba_pkg::REQ_W'(1)) ?
                    bba_pkg::floor_log2(n_dec) + bba_pkg::LOG_W'(1) : '0;
    assign flog   = bba_pkg::floor_log2(n);
    assign need7  = 7'(need);
    assign sp7    = 7'(flog) + 7'd2;
    assign fit7   = (need7 > BS_W7) ? need7 - BS_W7 : '0;
    assign split7 = (sp7 > BS_W7) ? sp7 - BS_W7 : '0;

    assign req.mode      = s_tuser[0];
    assign req.rel_off   = s_tdata[40:21];
    assign req.fit_lvl   = fit7[bba_pkg::LOG_W-1:0];
    assign req.split_lvl = split7[bba_pkg::LOG_W-1:0];
    assign req.req_zero  = (n == '0);

    assign s_tready = stat.idle;
    assign start    = s_tvalid && stat.idle;

    bba_walk #(
        .LEVELS      (LEVELS),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .req      (req),
        .res_take (res_take),
        .stat     (stat)
    );

    // Output register
    logic                      m_valid_reg;
    logic                      ok_reg;
    logic [bba_pkg::OFF_W-1:0] off_reg;

    assign res_take = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.res_valid && res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (stat.res_valid && res_take) begin
            ok_reg  <= stat.res_ok;
            off_reg <= stat.res_off;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {4'b0, off_reg};
    assign m_tuser[0] = ok_reg;

endmodule

`default_nettype wire
